[hdl/mpbb_pkg.sv]
package mpbb_pkg;

    localparam int COORD_W = 32;
    localparam int BOUND_W = 34;
    localparam int WIDTH_W = 31;
    localparam int STYLE_W = 3;
    localparam int HALF_W  = WIDTH_W - 1;
    localparam int BOX_W   = 33;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 136;
    localparam int CFG_IDX_W  = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_STYLE  = 1'd1;

    typedef logic signed [BOUND_W-1:0] bound_t;

    // empty-box start values: min at the top of the range, max at the bottom
    localparam bound_t BOUND_HI = {1'b0, {(BOUND_W-1){1'b1}}};
    localparam bound_t BOUND_LO = {1'b1, {(BOUND_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        bound_t min_x;
        bound_t min_y;
        bound_t max_x;
        bound_t max_y;
    } bounds_t;

    // path state as seen by the box stage for the vertex being processed
    typedef struct packed {
        bounds_t bnd;    // bounds including this vertex and its segment
        point_t  first;  // first vertex of the path
        point_t  near;   // neighbor of the first vertex
        point_t  prev;   // vertex before this one
        logic    multi;  // at least two vertices including this one
    } track_t;

    typedef enum logic [1:0] {
        END_MIN_X,
        END_MAX_X,
        END_MIN_Y,
        END_MAX_Y
    } end_dir_t;

    typedef struct packed {
        end_dir_t dir;
        bound_t   val;
    } reach_t;

    function automatic bound_t sext_coord(input logic signed [COORD_W-1:0] c);
        sext_coord = $signed({{(BOUND_W-COORD_W){c[COORD_W-1]}}, c});
    endfunction

    function automatic bound_t zext_half(input logic [HALF_W-1:0] h);
        zext_half = $signed({{(BOUND_W-HALF_W){1'b0}}, h});
    endfunction

    // Reach of an end vertex e past its neighbor n, half a width outward.
    function automatic reach_t end_reach(input point_t e, input point_t n,
                                         input logic [HALF_W-1:0] half);
        reach_t r;
        bound_t h;
        h = zext_half(half);
        if (e.x == n.x) begin
            if (e.y < n.y) begin
                r.dir = END_MIN_Y;
                r.val = sext_coord(e.y) - h;
            end else begin
                r.dir = END_MAX_Y;
                r.val = sext_coord(e.y) + h;
            end
        end else begin
            if (e.x < n.x) begin
                r.dir = END_MIN_X;
                r.val = sext_coord(e.x) - h;
            end else begin
                r.dir = END_MAX_X;
                r.val = sext_coord(e.x) + h;
            end
        end
        end_reach = r;
    endfunction

endpackage

[hdl/mpbb_in_stage.sv]
module mpbb_in_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mpbb_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  logic                             advance,
    output logic                             in_valid,
    output mpbb_pkg::point_t                 pt,
    output logic                             last
);
    import mpbb_pkg::*;

    logic   valid_reg, valid_next;
    point_t pt_reg;
    logic   last_reg;
    logic   take;

    // the register frees up in the same cycle its item moves on
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pt_reg.x <= $signed(s_tdata[COORD_W-1:0]);
            pt_reg.y <= $signed(s_tdata[2*COORD_W-1:COORD_W]);
            last_reg <= s_tlast;
        end
    end

    assign in_valid = valid_reg;
    assign pt       = pt_reg;
    assign last     = last_reg;

endmodule

[hdl/mpbb_track.sv]
module mpbb_track (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  mpbb_pkg::point_t              pt,
    input  logic                          last,
    input  logic [mpbb_pkg::HALF_W-1:0]   half,
    output mpbb_pkg::track_t              trk
);
    import mpbb_pkg::*;

    logic [1:0] count_reg, count_next;
    bounds_t    bnd_reg, bnd_next;
    point_t     first_reg, second_reg, prev_reg;

    bounds_t upd;
    bound_t  px, py, h;
    bound_t  lo_x, hi_x, lo_y, hi_y;
    logic    seg, vert;

    always_comb begin
        px   = sext_coord(pt.x);
        py   = sext_coord(pt.y);
        h    = zext_half(half);
        seg  = (count_reg != 2'd0);
        vert = (prev_reg.x == pt.x);

        // widen across the segment ending here: in x if vertical, else in y
        lo_x = (seg && vert)  ? px - h : px;
        hi_x = (seg && vert)  ? px + h : px;
        lo_y = (seg && !vert) ? py - h : py;
        hi_y = (seg && !vert) ? py + h : py;

        upd.min_x = (lo_x < bnd_reg.min_x) ? lo_x : bnd_reg.min_x;
        upd.max_x = (hi_x > bnd_reg.max_x) ? hi_x : bnd_reg.max_x;
        upd.min_y = (lo_y < bnd_reg.min_y) ? lo_y : bnd_reg.min_y;
        upd.max_y = (hi_y > bnd_reg.max_y) ? hi_y : bnd_reg.max_y;
    end

    always_comb begin
        trk.bnd   = upd;
        trk.first = (count_reg == 2'd0) ? pt : first_reg;
        trk.near  = (count_reg == 2'd1) ? pt : second_reg;
        trk.prev  = prev_reg;
        trk.multi = seg;
    end

    always_comb begin
        count_next = count_reg;
        bnd_next   = bnd_reg;
        if (advance) begin
            if (last) begin
                count_next = 2'd0;
                bnd_next   = '{min_x: BOUND_HI, min_y: BOUND_HI,
                               max_x: BOUND_LO, max_y: BOUND_LO};
            end else begin
                count_next = (count_reg == 2'd2) ? 2'd2 : count_reg + 2'd1;
                bnd_next   = upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            bnd_reg   <= '{min_x: BOUND_HI, min_y: BOUND_HI,
                           max_x: BOUND_LO, max_y: BOUND_LO};
        end else begin
            count_reg <= count_next;
            bnd_reg   <= bnd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !last) begin
            prev_reg <= pt;
            if (count_reg == 2'd0) begin
                first_reg <= pt;
            end
            if (count_reg == 2'd1) begin
                second_reg <= pt;
            end
        end
    end

endmodule

[hdl/mpbb_box.sv]
module mpbb_box (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  mpbb_pkg::point_t                pt,
    input  logic                            last,
    input  mpbb_pkg::track_t                trk,
    input  logic [mpbb_pkg::HALF_W-1:0]     half,
    input  logic                            width_nz,
    input  logic                            end_nz,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mpbb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tuser
);
    import mpbb_pkg::*;

    logic   valid_reg, valid_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic   ok_reg, ok_next;

    reach_t  r_start, r_end;
    bounds_t fin;
    bound_t  span_x, span_y;

    function automatic bound_t lower(input bound_t b, input logic on, input bound_t v);
        lower = (on && v < b) ? v : b;
    endfunction

    function automatic bound_t raise(input bound_t b, input logic on, input bound_t v);
        raise = (on && v > b) ? v : b;
    endfunction

    always_comb begin
        r_start = end_reach(trk.first, trk.near, half);
        r_end   = end_reach(pt, trk.prev, half);

        fin.min_x = lower(trk.bnd.min_x, end_nz && r_start.dir == END_MIN_X, r_start.val);
        fin.min_x = lower(fin.min_x,     end_nz && r_end.dir == END_MIN_X,   r_end.val);
        fin.max_x = raise(trk.bnd.max_x, end_nz && r_start.dir == END_MAX_X, r_start.val);
        fin.max_x = raise(fin.max_x,     end_nz && r_end.dir == END_MAX_X,   r_end.val);
        fin.min_y = lower(trk.bnd.min_y, end_nz && r_start.dir == END_MIN_Y, r_start.val);
        fin.min_y = lower(fin.min_y,     end_nz && r_end.dir == END_MIN_Y,   r_end.val);
        fin.max_y = raise(trk.bnd.max_y, end_nz && r_start.dir == END_MAX_Y, r_start.val);
        fin.max_y = raise(fin.max_y,     end_nz && r_end.dir == END_MAX_Y,   r_end.val);

        span_x = fin.max_x - fin.min_x;
        span_y = fin.max_y - fin.min_y;

        ok_next   = width_nz && trk.multi;
        data_next = '0;
        if (ok_next) begin
            data_next[BOX_W-1:0]         = fin.min_x[BOX_W-1:0];
            data_next[2*BOX_W-1:BOX_W]   = fin.min_y[BOX_W-1:0];
            data_next[3*BOX_W-1:2*BOX_W] = span_x[BOX_W-1:0];
            data_next[4*BOX_W-1:3*BOX_W] = span_y[BOX_W-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last) begin
            data_reg <= data_next;
            ok_reg   <= ok_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = ok_reg;

endmodule

[hdl/manhattan_path_bounding_box_core.sv]
// Channel   Dir  tdata (low bit first)                             tlast / tuser
// --------  ---  ------------------------------------------------  ------------------
// s_        in   point_x[31:0], point_y[63:32]                     tlast = point_last
// m_        out  box_left, box_bottom, box_span_x, box_span_y      tuser = box_ok
//                (33 bits each, [131:0], zero fill to [135:0])
// cfg_      in   index 0 path_width (31 bits), index 1 end_style (3 bits)
//
// One item per cycle sustained while no held box blocks the result register; the last
// vertex of a path is taken into the input register, then the bound update and end
// extension feed the result register, from which the box leaves.
// The running bounds live in one register set updated per vertex.
// Reset (aresetn low, synchronous) empties both stages, clears the path state and
// sets path_width and end_style to zero.
// A held result stalls the input only once the input register is also full.
module manhattan_path_bounding_box_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // vertex stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mpbb_pkg::IN_DATA_W-1:0]    s_tdata,   // point_x, point_y
    input  logic                              s_tlast,   // point_last
    // box stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mpbb_pkg::OUT_DATA_W-1:0]   m_tdata,   // box_left, box_bottom,
                                                         // box_span_x, box_span_y
    output logic                              m_tuser,   // box_ok
    // register writes
    input  logic                              cfg_we,
    input  logic [mpbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mpbb_pkg::WIDTH_W-1:0]      cfg_data
);
    import mpbb_pkg::*;

    logic [WIDTH_W-1:0] path_width_reg;
    logic [STYLE_W-1:0] end_style_reg;
    logic [HALF_W-1:0]  half;

    logic    in_valid;
    point_t  pt;
    logic    last;
    logic    advance;
    track_t  trk;

    // configuration: the user must write it only while the path stream is idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_width_reg <= '0;
            end_style_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PATH_WIDTH: path_width_reg <= cfg_data;
                CFG_END_STYLE:  end_style_reg  <= cfg_data[STYLE_W-1:0];
                default:        path_width_reg <= path_width_reg;
            endcase
        end
    end

    assign half = path_width_reg[WIDTH_W-1:1];

    // advance the vertex in the input register when the result slot can take it
    assign advance = in_valid && (!m_tvalid || m_tready);

    mpbb_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .in_valid (in_valid),
        .pt       (pt),
        .last     (last)
    );

    // running bounds and the remembered vertices of the current path
    mpbb_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .pt      (pt),
        .last    (last),
        .half    (half),
        .trk     (trk)
    );

    // end extension, failure check and the result register
    mpbb_box u_box (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .pt       (pt),
        .last     (last),
        .trk      (trk),
        .half     (half),
        .width_nz (path_width_reg != '0),
        .end_nz   (end_style_reg != '0),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
